// ===== rtl/led_strip_pattern_engine_assert.svh =====
// ----------------------------------------------------------------------------
// LED strip pattern engine assertion macros
// Shared macros for the concurrent checks on the engine's ports.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PATTERN_ENGINE_ASSERT_SVH
`define LED_STRIP_PATTERN_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSPE_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("lspe port check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSPE_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("lspe port check failed");

`endif

// ===== rtl/lspe_pkg.sv =====
// ----------------------------------------------------------------------------
// lspe_pkg
// Sizes, pattern constants, color tables and controller/datapath links.
// ----------------------------------------------------------------------------
package lspe_pkg;

  localparam int NUM_LEDS   = 32;
  localparam int BEAM_WIDTH = 4;

  localparam int FRAME_W = 10;
  localparam int COLOR_W = 24;
  localparam int POS_W   = 6;
  localparam int MODE_W  = 3;
  localparam int LED_W   = $clog2(NUM_LEDS);
  localparam int P_W     = $clog2(NUM_LEDS + 1);

  // Pattern mode codes.
  localparam logic [MODE_W-1:0] MODE_SCANNER = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PULSE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT_CW  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT_CCW = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BAR     = 3'd4;

  // Register indexes.
  localparam logic REG_PATTERN_MODE = 1'b0;

  // Pulse sub-patterns.
  localparam logic [1:0] PULSE_SOLID = 2'd0;
  localparam logic [1:0] PULSE_ODD   = 2'd1;
  localparam logic [1:0] PULSE_EVEN  = 2'd2;
  localparam int PULSE_COLORS = 7;
  localparam int PULSE_STATES = 3;

  // Scanner and bar graph periods.
  localparam int SCAN_SPAN   = NUM_LEDS - BEAM_WIDTH;
  localparam int SCAN_PERIOD = 2 * SCAN_SPAN;
  localparam int BAR_PERIOD  = 2 * NUM_LEDS;
  localparam int REM_W       = $clog2(BAR_PERIOD);

  // End counts.
  localparam int DONE_SCAN  = 6 * SCAN_SPAN;
  localparam int DONE_PULSE = PULSE_COLORS * PULSE_STATES;
  localparam int DONE_ROT   = 3 * NUM_LEDS;
  localparam int DONE_BAR   = 4 * NUM_LEDS;

  // Reciprocals for exact quotients of a frame index by small constants.
  localparam int RECIP_SHIFT = 20;
  localparam int unsigned RECIP_SCAN  = ((1 << RECIP_SHIFT) + SCAN_PERIOD - 1) / SCAN_PERIOD;
  localparam int unsigned RECIP_BAR   = ((1 << RECIP_SHIFT) + BAR_PERIOD - 1) / BAR_PERIOD;
  localparam int unsigned RECIP_PULSE = ((1 << RECIP_SHIFT) + PULSE_STATES - 1) / PULSE_STATES;

  localparam logic [COLOR_W-1:0] COLOR_RED   = 24'h00007F;
  localparam logic [COLOR_W-1:0] COLOR_GREEN = 24'h007F00;
  localparam logic [COLOR_W-1:0] COLOR_BLUE  = 24'h7F0000;

  // Rotate seeds, already moved by the first rotation step.
  localparam int SEED_RED_AT   = 0;
  localparam int SEED_BLUE_AT  = 10;
  localparam int SEED_GREEN_AT = 20;
  localparam bit SEED_RED_ON   = SEED_RED_AT < NUM_LEDS;
  localparam bit SEED_BLUE_ON  = SEED_BLUE_AT < NUM_LEDS;
  localparam bit SEED_GREEN_ON = SEED_GREEN_AT < NUM_LEDS;
  localparam logic [LED_W-1:0] SEED_CW_RED    = LED_W'((SEED_RED_AT + 1) % NUM_LEDS);
  localparam logic [LED_W-1:0] SEED_CW_BLUE   = LED_W'((SEED_BLUE_AT + 1) % NUM_LEDS);
  localparam logic [LED_W-1:0] SEED_CW_GREEN  = LED_W'((SEED_GREEN_AT + 1) % NUM_LEDS);
  localparam logic [LED_W-1:0] SEED_CCW_RED   =
    LED_W'((SEED_RED_AT + NUM_LEDS - 1) % NUM_LEDS);
  localparam logic [LED_W-1:0] SEED_CCW_BLUE  =
    LED_W'((SEED_BLUE_AT + NUM_LEDS - 1) % NUM_LEDS);
  localparam logic [LED_W-1:0] SEED_CCW_GREEN =
    LED_W'((SEED_GREEN_AT + NUM_LEDS - 1) % NUM_LEDS);

  // Bar graph brightness, 255*p/N for every bar length p.
  typedef logic [7:0] bar_table_t [0:NUM_LEDS];

  function automatic bar_table_t make_bar_table();
    bar_table_t tbl;
    for (int p = 0; p <= NUM_LEDS; p++) begin
      tbl[p] = 8'((255 * p) / NUM_LEDS);
    end
    return tbl;
  endfunction

  localparam bar_table_t BAR_LEVEL = make_bar_table();

  // Pulse colors; indexes past the table fall back to the first color.
  function automatic logic [COLOR_W-1:0] pulse_color(input logic [FRAME_W-1:0] sel);
    logic [COLOR_W-1:0] c;
    case (sel)
      10'd1:   c = 24'h00007F;
      10'd2:   c = 24'h007F00;
      10'd3:   c = 24'h7F0000;
      10'd4:   c = 24'h003F3F;
      10'd5:   c = 24'h3F3F00;
      10'd6:   c = 24'h3F003F;
      default: c = 24'h3F3F3F;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic             capture;
    logic             quo_en;
    logic             rem_en;
    logic             emit;
    logic [LED_W-1:0] led;
  } lspe_cmd_t;

  typedef struct packed {
    logic out_free;
  } lspe_status_t;

endpackage

// ===== rtl/lspe_ctrl.sv =====
// ----------------------------------------------------------------------------
// lspe_ctrl
// Frame sequencer: captures a tick, runs the setup steps, then walks the LEDs.
// ----------------------------------------------------------------------------
module lspe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lspe_pkg::lspe_status_t status,
  output lspe_pkg::lspe_cmd_t    cmd
);
  import lspe_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_QUO, ST_REM, ST_EMIT} state_t;

  state_t           state;
  logic [LED_W-1:0] led;

  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = in_valid && (state == ST_IDLE);
  assign cmd.quo_en  = (state == ST_QUO);
  assign cmd.rem_en  = (state == ST_REM);
  assign cmd.emit    = (state == ST_EMIT) && status.out_free;
  assign cmd.led     = led;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      led   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_QUO;
        end
        ST_QUO: state <= ST_REM;
        ST_REM: begin
          led   <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (status.out_free) begin
            led <= led + 1'b1;
            if (led == LED_W'(NUM_LEDS - 1)) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lspe_dp.sv =====
// ----------------------------------------------------------------------------
// lspe_dp
// Frame arithmetic, the frame store with its rotation offset, and the output
// register.
// ----------------------------------------------------------------------------
module lspe_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  lspe_pkg::lspe_cmd_t          cmd,
  output lspe_pkg::lspe_status_t       status,
  input  logic [lspe_pkg::MODE_W-1:0]  pattern_mode,
  input  logic [lspe_pkg::FRAME_W-1:0] frame_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lspe_pkg::COLOR_W-1:0] led_color,
  output logic [lspe_pkg::POS_W-1:0]   led_position,
  output logic                         last_led,
  output logic                         pattern_done
);
  import lspe_pkg::*;

  logic [FRAME_W-1:0] f_reg;
  logic [FRAME_W-1:0] q_scan, q_bar, q_pulse;
  logic [31:0]        prod_scan, prod_bar, prod_pulse;

  logic [15:0]        r_scan16, r_bar16, r_pulse16;
  logic [REM_W-1:0]   r_scan, r_bar;
  logic [LED_W-1:0]   pos_next;
  logic [P_W-1:0]     p_next;
  logic               rotating, done_next;

  logic [LED_W-1:0]   pos_q;
  logic [P_W-1:0]     p_q;
  logic [1:0]         sub_q;
  logic [COLOR_W-1:0] pulse_q;
  logic               done_q, zero_q, ovw_q;
  logic [LED_W-1:0]   base;

  logic [COLOR_W-1:0] frame_store [NUM_LEDS];
  logic [LED_W:0]     addr_sum;
  logic [LED_W-1:0]   addr;
  logic [LED_W-1:0]   beam_off;
  logic [COLOR_W-1:0] color;

  // Quotients by reciprocal multiplication; exact over the whole frame range.
  assign prod_scan  = 32'(f_reg) * RECIP_SCAN;
  assign prod_bar   = 32'(f_reg) * RECIP_BAR;
  assign prod_pulse = 32'(f_reg) * RECIP_PULSE;

  always_ff @(posedge clk) begin
    if (cmd.capture) f_reg <= frame_index;
    if (cmd.quo_en) begin
      q_scan  <= prod_scan[RECIP_SHIFT +: FRAME_W];
      q_bar   <= prod_bar[RECIP_SHIFT +: FRAME_W];
      q_pulse <= prod_pulse[RECIP_SHIFT +: FRAME_W];
    end
  end

  assign rotating = (pattern_mode == MODE_ROT_CW) || (pattern_mode == MODE_ROT_CCW);

  always_comb begin
    r_scan16  = 16'(f_reg) - 16'(q_scan) * 16'(SCAN_PERIOD);
    r_bar16   = 16'(f_reg) - 16'(q_bar) * 16'(BAR_PERIOD);
    r_pulse16 = 16'(f_reg) - 16'(q_pulse) * 16'(PULSE_STATES);
    r_scan    = r_scan16[REM_W-1:0];
    r_bar     = r_bar16[REM_W-1:0];
    // The beam moves out and folds back at the far end.
    if (r_scan < REM_W'(SCAN_SPAN)) pos_next = LED_W'(r_scan);
    else                            pos_next = LED_W'(REM_W'(SCAN_PERIOD) - r_scan);
    if (r_bar < REM_W'(NUM_LEDS)) p_next = P_W'(r_bar);
    else                          p_next = P_W'(REM_W'(BAR_PERIOD) - r_bar);
    case (pattern_mode)
      MODE_PULSE:   done_next = int'(f_reg) >= DONE_PULSE;
      MODE_ROT_CW,
      MODE_ROT_CCW: done_next = int'(f_reg) >= DONE_ROT;
      MODE_BAR:     done_next = int'(f_reg) >= DONE_BAR;
      default:      done_next = int'(f_reg) >= DONE_SCAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rem_en) begin
      pos_q   <= pos_next;
      p_q     <= p_next;
      sub_q   <= r_pulse16[1:0];
      pulse_q <= pulse_color(q_pulse);
      done_q  <= done_next;
      zero_q  <= (f_reg == '0);
      ovw_q   <= !rotating || (f_reg == '0);
    end
  end

  // A rotation only moves the offset; every other frame rewrites the store
  // from offset zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cmd.rem_en) begin
      if (rotating && (f_reg != '0)) begin
        if (pattern_mode == MODE_ROT_CW) begin
          base <= (base == '0) ? LED_W'(NUM_LEDS - 1) : base - 1'b1;
        end else begin
          base <= (base == LED_W'(NUM_LEDS - 1)) ? '0 : base + 1'b1;
        end
      end else begin
        base <= '0;
      end
    end
  end

  always_comb begin
    addr_sum = (LED_W + 1)'(cmd.led) + (LED_W + 1)'(base);
    if (addr_sum >= (LED_W + 1)'(NUM_LEDS)) addr_sum = addr_sum - (LED_W + 1)'(NUM_LEDS);
    addr     = addr_sum[LED_W-1:0];
    beam_off = cmd.led - pos_q;
  end

  always_comb begin
    color = '0;
    case (pattern_mode)
      MODE_PULSE: begin
        if ((sub_q == PULSE_SOLID) || (sub_q == PULSE_ODD && cmd.led[0]) ||
            (sub_q == PULSE_EVEN && !cmd.led[0])) begin
          color = pulse_q;
        end
      end
      MODE_ROT_CW: begin
        if (!zero_q) begin
          color = frame_store[addr];
        end else begin
          if (SEED_RED_ON && cmd.led == SEED_CW_RED) color = COLOR_RED;
          if (SEED_BLUE_ON && cmd.led == SEED_CW_BLUE) color = COLOR_BLUE;
          if (SEED_GREEN_ON && cmd.led == SEED_CW_GREEN) color = COLOR_GREEN;
        end
      end
      MODE_ROT_CCW: begin
        if (!zero_q) begin
          color = frame_store[addr];
        end else begin
          if (SEED_RED_ON && cmd.led == SEED_CCW_RED) color = COLOR_RED;
          if (SEED_BLUE_ON && cmd.led == SEED_CCW_BLUE) color = COLOR_BLUE;
          if (SEED_GREEN_ON && cmd.led == SEED_CCW_GREEN) color = COLOR_GREEN;
        end
      end
      MODE_BAR: begin
        if (P_W'(cmd.led) < p_q) color = {BAR_LEVEL[p_q], 16'h0000};
        else color = {8'h00, BAR_LEVEL[P_W'(NUM_LEDS) - p_q], 8'h00};
      end
      default: begin
        if ((cmd.led >= pos_q) && (beam_off < LED_W'(BEAM_WIDTH))) color = COLOR_RED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEDS; i++) frame_store[i] <= '0;
    end else if (cmd.emit && ovw_q) begin
      frame_store[addr] <= color;
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      led_color    <= color;
      led_position <= POS_W'(cmd.led);
      last_led     <= (cmd.led == LED_W'(NUM_LEDS - 1));
      pattern_done <= done_q;
    end
  end

endmodule

// ===== rtl/led_strip_pattern_engine.sv =====
// ----------------------------------------------------------------------------
// led_strip_pattern_engine
// Frame-tick driven LED strip animator with an APB mode register.
// ----------------------------------------------------------------------------
// Each accepted item is one frame tick carrying its frame index. The engine
// updates its stored frame for the mode held in pattern_mode and then streams
// out one result item per LED, LED 0 first, each with its position, a flag on
// the final LED and the pattern-done flag. A frame first runs its setup steps
// (capture, a reciprocal-multiply quotient step and a remainder step) and then
// walks the LEDs, one per cycle while the output side keeps taking items,
// through the single write port of the frame store. The next tick is accepted
// as soon as the last LED has been loaded into the output register, even if
// that item has not yet been taken. Rotations do not move data: they step an
// offset into the store, and all other frames rewrite the store one LED per
// cycle while the output side keeps taking items.
module led_strip_pattern_engine (
  input  logic                         clk,
  input  logic                         rst,
  // Frame tick channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lspe_pkg::FRAME_W-1:0] frame_index,
  // LED color channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lspe_pkg::COLOR_W-1:0] led_color,
  output logic [lspe_pkg::POS_W-1:0]   led_position,
  output logic                         last_led,
  output logic                         pattern_done,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lspe_pkg::*;

  logic [MODE_W-1:0] pattern_mode;
  lspe_cmd_t         cmd;
  lspe_status_t      status;

  // The only register sits at byte address zero; bit 2 selects the word.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= MODE_SCANNER;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PATTERN_MODE)) begin
      pattern_mode <= pwdata[MODE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PATTERN_MODE) ? 32'(pattern_mode) : '0;

  lspe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lspe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .pattern_mode (pattern_mode),
    .frame_index  (frame_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .led_color    (led_color),
    .led_position (led_position),
    .last_led     (last_led),
    .pattern_done (pattern_done)
  );

endmodule

// ===== rtl/lspe_checker.sv =====
// ----------------------------------------------------------------------------
// lspe_checker
// Port-level checks on the engine's frame and LED channels.
// ----------------------------------------------------------------------------
`include "led_strip_pattern_engine_assert.svh"

module lspe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lspe_pkg::COLOR_W-1:0] led_color,
  input logic [lspe_pkg::POS_W-1:0]   led_position,
  input logic                         last_led,
  input logic                         pattern_done
);
  import lspe_pkg::*;

  // A stalled result item holds still.
  `LSPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(led_color) && $stable(led_position) && $stable(last_led) && $stable(pattern_done))

  // The final-LED flag marks only the top position.
  `LSPE_ASSERT_NOW(a_last_pos, out_valid && last_led, led_position == POS_W'(NUM_LEDS - 1))

  // Within a frame the next LED follows right after one is taken.
  `LSPE_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !last_led, out_valid)

  // A frame tick closes the input until its LEDs are on their way.
  `LSPE_ASSERT_NEXT(a_one_frame, in_valid && in_ready, !in_ready)

endmodule

bind led_strip_pattern_engine lspe_checker u_lspe_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: LED strip pattern engine testbench
// Drives frame ticks into the engine and checks every LED color item that
// comes back against an independent frame predictor. The mode register is
// programmed over APB between bursts while the engine is idle. A directed
// pass covers each pattern's corners, and a random pass covers many
// animation runs under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import lspe_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_TICKS = 9;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int PRINT_LIMIT = 40;
  // The tail wait at the end gives the engine a little more time than one frame
  // takes, so that stray items can show.
  localparam int DRAIN_TAIL  = 40;

  // APB addresses: the mode register, and a hole with no register behind it.
  localparam logic [2:0] ADDR_PATTERN_MODE = 3'd0;
  localparam logic [2:0] ADDR_UNUSED       = 3'd4;

  // Mode codes the engine does not define; they must fall back to the scanner.
  localparam logic [MODE_W-1:0] MODE_UNDEF_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNDEF_HI = 3'd7;

  localparam int PULSE_SHADES = 7;
  localparam int PULSE_PHASES = 3;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   pos;
    logic               is_last;
    logic               is_done;
  } led_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FRAME_W-1:0]   frame_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [COLOR_W-1:0]   led_color;
  logic [POS_W-1:0]     led_position;
  logic                 last_led;
  logic                 pattern_done;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Predictor state: the mode register and the stored frame as the engine
  // should hold them after every accepted item.
  logic [MODE_W-1:0]    model_mode;
  logic [COLOR_W-1:0]   led_frame [NUM_LEDS];
  led_result_t          led_expect_q [$];

  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;

  led_strip_pattern_engine uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_index  (frame_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .led_color    (led_color),
    .led_position (led_position),
    .last_led     (last_led),
    .pattern_done (pattern_done),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog. A correct run finishes far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** led_strip_pattern_engine: FAILED **");
      $finish;
    end
  end

  // The receiver stalls at random with the rate of the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t ns] mismatch: %s", $time, what);
    end
  endtask

  // Every LED color item the engine hands over is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin : check_led_items
    led_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (led_expect_q.size() == 0) begin
        report_mismatch($sformatf("item for LED %0d with nothing predicted", led_position));
      end else begin
        want = led_expect_q.pop_front();
        if (led_color !== want.color) begin
          report_mismatch($sformatf("LED %0d color %06h, predicted %06h",
                                    want.pos, led_color, want.color));
        end
        if (led_position !== want.pos) begin
          report_mismatch($sformatf("position %0d, predicted %0d", led_position, want.pos));
        end
        if (last_led !== want.is_last) begin
          report_mismatch($sformatf("LED %0d last flag %b, predicted %b",
                                    want.pos, last_led, want.is_last));
        end
        if (pattern_done !== want.is_done) begin
          report_mismatch($sformatf("LED %0d done flag %b, predicted %b",
                                    want.pos, pattern_done, want.is_done));
        end
      end
    end
  end

  // Updates the predicted frame for one frame tick and queues the 32 LED
  // items the engine should then emit.
  function automatic void predict_frame(input logic [FRAME_W-1:0] f);
    int unsigned        fi;
    int unsigned        span;
    int unsigned        c;
    int unsigned        beam_start;
    int unsigned        m;
    int unsigned        bar_len;
    int unsigned        phase;
    logic [COLOR_W-1:0] hold;
    logic [COLOR_W-1:0] shade;
    logic [COLOR_W-1:0] bar_color;
    logic [COLOR_W-1:0] rest_color;
    logic               lit;
    logic               done_flag;
    led_result_t        r;
    fi = f;
    case (model_mode)
      MODE_PULSE: begin
        // Past the seventh color the pulse falls back to the first one.
        case (fi / PULSE_PHASES)
          1:       shade = 24'h00007F;
          2:       shade = 24'h007F00;
          3:       shade = 24'h7F0000;
          4:       shade = 24'h003F3F;
          5:       shade = 24'h3F3F00;
          6:       shade = 24'h3F003F;
          default: shade = 24'h3F3F3F;
        endcase
        phase = fi % PULSE_PHASES;
        for (int i = 0; i < NUM_LEDS; i++) begin
          lit = (phase == 0) || (phase == 1 && i[0]) || (phase == 2 && !i[0]);
          led_frame[i] = lit ? shade : '0;
        end
        done_flag = (fi >= PULSE_SHADES * PULSE_PHASES);
      end
      MODE_ROT_CW, MODE_ROT_CCW: begin
        // Frame zero restarts the rotation from the three seeds; any other
        // frame rotates whatever the store already holds.
        if (fi == 0) begin
          for (int i = 0; i < NUM_LEDS; i++) led_frame[i] = '0;
          if (0 < NUM_LEDS) led_frame[0] = COLOR_RED;
          if (10 < NUM_LEDS) led_frame[10] = COLOR_BLUE;
          if (20 < NUM_LEDS) led_frame[20] = COLOR_GREEN;
        end
        if (model_mode == MODE_ROT_CW) begin
          hold = led_frame[NUM_LEDS-1];
          for (int i = NUM_LEDS - 1; i > 0; i--) led_frame[i] = led_frame[i-1];
          led_frame[0] = hold;
        end else begin
          hold = led_frame[0];
          for (int i = 0; i < NUM_LEDS - 1; i++) led_frame[i] = led_frame[i+1];
          led_frame[NUM_LEDS-1] = hold;
        end
        done_flag = (fi >= 3 * NUM_LEDS);
      end
      MODE_BAR: begin
        m = fi % (2 * NUM_LEDS);
        bar_len = (m < NUM_LEDS) ? m : 2 * NUM_LEDS - m;
        bar_color = COLOR_W'(((255 * bar_len) / NUM_LEDS) << 16);
        rest_color = COLOR_W'(((255 * (NUM_LEDS - bar_len)) / NUM_LEDS) << 8);
        for (int i = 0; i < NUM_LEDS; i++) begin
          led_frame[i] = (i < bar_len) ? bar_color : rest_color;
        end
        done_flag = (fi >= 4 * NUM_LEDS);
      end
      default: begin
        // Scanner, also taken by the undefined mode codes.
        span = NUM_LEDS - BEAM_WIDTH;
        c = fi % (2 * span);
        beam_start = (c < span) ? c : 2 * span - c;
        for (int i = 0; i < NUM_LEDS; i++) led_frame[i] = '0;
        for (int b = 0; b < BEAM_WIDTH; b++) begin
          if (beam_start + b < NUM_LEDS) led_frame[beam_start + b] = COLOR_RED;
        end
        done_flag = (fi >= 6 * span);
      end
    endcase
    for (int i = 0; i < NUM_LEDS; i++) begin
      r.color = led_frame[i];
      r.pos = POS_W'(i);
      r.is_last = (i == NUM_LEDS - 1);
      r.is_done = done_flag;
      led_expect_q.push_back(r);
    end
  endfunction

  // Offers one frame tick and returns at the falling edge after it was
  // accepted. Valid stays high so that a following item can go out back to
  // back; release_sender lowers it when the burst is over.
  task automatic send_frame(input logic [FRAME_W-1:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_index <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frame(f);
    @(negedge clk);
  endtask

  task automatic release_sender();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (led_expect_q.size() != 0) @(negedge clk);
  endtask

  // One APB write: a setup phase, then an access phase that ends on the
  // edge where the register takes the data, then an idle phase.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_PATTERN_MODE) model_mode = data[MODE_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Waits for the engine to go idle, programs the mode with random filler in
  // the unused data bits, and reads it back.
  task automatic set_mode(input logic [MODE_W-1:0] mode);
    logic [31:0] data;
    wait_drained();
    data = $urandom;
    data[MODE_W-1:0] = mode;
    apb_write(ADDR_PATTERN_MODE, data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_PATTERN_MODE;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[MODE_W-1:0] !== model_mode) begin
      report_mismatch($sformatf("mode reads back %0d, written %0d",
                                prdata[MODE_W-1:0], model_mode));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Scanner: both ends of the bounce, the turn, the end count, and the
  // largest frame index.
  task automatic test_scanner();
    set_mode(MODE_SCANNER);
    send_frame(10'd0);
    send_frame(10'd28);
    send_frame(10'd55);
    send_frame(10'd168);
    send_frame(10'd1023);
    release_sender();
  endtask

  // Pulse: all three sub-patterns, the last table color, the index past the
  // table together with the end count, and the largest frame index.
  task automatic test_pulse();
    set_mode(MODE_PULSE);
    send_frame(10'd0);
    send_frame(10'd1);
    send_frame(10'd2);
    send_frame(10'd20);
    send_frame(10'd21);
    send_frame(10'd1023);
    release_sender();
  endtask

  // Rotation: first a mode change in the middle of a pattern, so that the
  // scanner beam gets rotated, then the seeding frame in both directions and
  // the end count.
  task automatic test_rotate();
    set_mode(MODE_SCANNER);
    send_frame(10'd3);
    release_sender();
    set_mode(MODE_ROT_CW);
    send_frame(10'd9);
    send_frame(10'd0);
    send_frame(10'd1);
    release_sender();
    set_mode(MODE_ROT_CCW);
    send_frame(10'd0);
    send_frame(10'd96);
    release_sender();
  endtask

  // Bar graph: empty bar, full bar, the way back down, and the end count.
  task automatic test_bar_graph();
    set_mode(MODE_BAR);
    send_frame(10'd0);
    send_frame(10'd32);
    send_frame(10'd63);
    send_frame(10'd128);
    release_sender();
  endtask

  // Undefined mode codes behave as the scanner. A write to the address hole
  // must leave the mode register alone.
  task automatic test_undefined_modes();
    set_mode(MODE_UNDEF_LO);
    apb_write(ADDR_UNUSED, $urandom);
    send_frame(10'd30);
    release_sender();
    set_mode(MODE_UNDEF_HI);
    send_frame(10'd40);
    release_sender();
  endtask

  // Random animation runs: a mode, then a run of consecutive frame indexes,
  // most of them starting at frame zero, some near the end counts and some
  // anywhere. A few stray indexes are mixed in, and now and then the sender
  // holds off until the engine has emitted everything.
  task automatic test_random_frames(input int items, input int idle_pct,
                                    input int stall_rate);
    int                 sent;
    int                 run_len;
    int                 pick;
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] start_frame;
    logic [FRAME_W-1:0] f;
    sent = 0;
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    while (sent < items) begin
      pick = $urandom_range(0, 11);
      mode = (pick < 10) ? MODE_W'(pick % 5) : MODE_W'($urandom_range(5, 7));
      set_mode(mode);
      pick = $urandom_range(0, 9);
      if (pick < 6) start_frame = '0;
      else if (pick < 8) start_frame = FRAME_W'($urandom_range(0, 180));
      else start_frame = FRAME_W'($urandom_range(0, 1023));
      run_len = $urandom_range(1, 24);
      for (int k = 0; k < run_len && sent < items; k++) begin
        if ($urandom_range(0, 9) == 0) f = FRAME_W'($urandom_range(0, 1023));
        else f = FRAME_W'(start_frame + k);
        send_frame(f);
        sent++;
        if ($urandom_range(0, 19) == 0) begin
          release_sender();
          wait_drained();
        end
      end
      release_sender();
    end
  endtask

  initial begin
    model_mode = MODE_SCANNER;
    for (int i = 0; i < NUM_LEDS; i++) led_frame[i] = '0;
    repeat (RESET_TICKS) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_scanner();
    test_pulse();
    test_rotate();
    test_bar_graph();
    test_undefined_modes();

    // Phases: no idling, sender idling, receiver stalling, then both.
    test_random_frames(97, 0, 0);
    test_random_frames(97, 57, 0);
    test_random_frames(97, 0, 57);
    test_random_frames(97, 13, 13);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** led_strip_pattern_engine: PASSED **");
    end else begin
      $display("** led_strip_pattern_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ===== led_strip_pattern_engine.f =====
+incdir+rtl
rtl/lspe_pkg.sv
rtl/lspe_ctrl.sv
rtl/lspe_dp.sv
rtl/led_strip_pattern_engine.sv
rtl/lspe_checker.sv
sim/tb_top.sv
